FILE: rtl/crc16fp_pkg.sv
`timescale 1ns / 1ps

package crc16fp_pkg;

  // CRC-16/MODBUS constants
  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Frame geometry
  localparam logic [15:0] HDR_BYTES  = 16'd7;
  localparam logic [15:0] MIN_BYTES  = 16'd9;   // header plus tail
  localparam logic [16:0] OVERHEAD   = 17'd11;  // header, CRC and tail
  localparam logic [15:0] POS_SAT    = 16'hFFFF;

  // Summary status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_SYNC      = 3'd2,
    ST_TYPE      = 3'd3,
    ST_LONG      = 3'd4,
    ST_TRUNCATED = 3'd5,
    ST_TAIL      = 3'd6,
    ST_CRC       = 3'd7
  } status_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_SYNC_FIRST   = 3'd0,
    CFG_SYNC_SECOND  = 3'd1,
    CFG_TAIL_FIRST   = 3'd2,
    CFG_TAIL_SECOND  = 3'd3,
    CFG_TYPE_LOWEST  = 3'd4,
    CFG_TYPE_HIGHEST = 3'd5
  } cfg_idx_t;

  // One result word
  typedef struct packed {
    logic        kind;       // 0 payload byte, 1 summary
    logic [7:0]  payload;
    status_t     status;
    logic [15:0] sequence_res;
    logic [7:0]  packet_type;
    logic [15:0] length;
    logic [15:0] rx_crc;
  } result_t;

endpackage

FILE: rtl/crc16fp_crc.sv
`timescale 1ns / 1ps

// One-byte CRC-16/MODBUS update, reflected, LSB first
module crc16fp_crc (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_in,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data_in};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ crc16fp_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

FILE: rtl/crc16fp_outq.sv
`timescale 1ns / 1ps

// Two-entry result queue; full is registered so upstream ready
// never depends on the downstream ready.
module crc16fp_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  crc16fp_pkg::result_t push_data,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_ready,
  output crc16fp_pkg::result_t out_data
);

  crc16fp_pkg::result_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign full      = (cnt_r == 2'd2);
  assign out_data  = slot_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // slot storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/crc16_frame_parser.sv
`timescale 1ns / 1ps

// Channel | Ports                           | Word
// --------+---------------------------------+-----------------------------------------
// input   | in_tvalid/in_tready/in_tdata    | one received byte, tlast on final byte
// output  | out_tvalid/out_tready/out_tdata | payload byte (tuser 0) or summary (tuser 1)
// config  | cfg_we/cfg_addr/cfg_wdata       | 8-bit register write, no read-back
//
// One byte per cycle sustained: the byte register feeds the header/CRC
// update (8-step CRC tree plus one 18-bit offset compare) straight into
// a two-entry result queue. A result is held in the byte register, then in a queue slot.
// Reset is synchronous, rst_n low; no clearing pass is needed.
// A stall on the output fills the queue, then holds the byte register
// and drops in_tready; ready comes from registers only.
module crc16_frame_parser #(
  parameter int MAX_PAYLOAD = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  input  logic        in_tlast,    // end_of_buffer
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] payload_byte, [10:8] status, [26:11] sequence_res,
  // [34:27] packet_type, [50:35] payload_length, [66:51] received_crc, rest zero
  output logic [71:0] out_tdata,
  output logic        out_tuser,   // result_kind
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [7:0]  cfg_wdata
);

  localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

  // configuration registers
  logic [7:0] sync1_r, sync2_r, tail1_r, tail2_r, type_lo_r, type_hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync1_r   <= 8'hAA;
      sync2_r   <= 8'h55;
      tail1_r   <= 8'h55;
      tail2_r   <= 8'hAA;
      type_lo_r <= 8'd1;
      type_hi_r <= 8'd5;
    end else if (cfg_we) begin
      case (cfg_addr)
        crc16fp_pkg::CFG_SYNC_FIRST:   sync1_r   <= cfg_wdata;
        crc16fp_pkg::CFG_SYNC_SECOND:  sync2_r   <= cfg_wdata;
        crc16fp_pkg::CFG_TAIL_FIRST:   tail1_r   <= cfg_wdata;
        crc16fp_pkg::CFG_TAIL_SECOND:  tail2_r   <= cfg_wdata;
        crc16fp_pkg::CFG_TYPE_LOWEST:  type_lo_r <= cfg_wdata;
        crc16fp_pkg::CFG_TYPE_HIGHEST: type_hi_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input byte register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       q_full;
  logic       s1_go;
  logic       in_acc;

  assign in_tready = !s1_valid_r || !q_full;
  assign in_acc    = in_tvalid && in_tready;
  assign s1_go     = s1_valid_r && !q_full;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // frame state
  logic [15:0] pos_r, pos_nxt, pos_upd;
  logic [15:0] crc_r, crc_nxt, crc_upd;
  logic [15:0] seq_r, seq_nxt, seq_upd;
  logic [7:0]  type_r, type_nxt, type_upd;
  logic [15:0] len_r, len_nxt, len_upd;
  logic [15:0] rcrc_r, rcrc_nxt, rcrc_upd;
  logic        sync_ok_r, sync_ok_nxt, sync_ok_upd;
  logic        tail_ok_r, tail_ok_nxt, tail_ok_upd;
  logic [15:0] crc_step;
  logic [17:0] off;
  logic        is_pay;
  crc16fp_pkg::status_t    st;
  crc16fp_pkg::result_t    q_data;
  logic                    q_push;
  crc16fp_pkg::result_t    q_out;

  crc16fp_crc u_crc (
    .crc_in  (crc_r),
    .data_in (s1_byte_r),
    .crc_out (crc_step)
  );

  // position relative to the first CRC byte; negative inside the payload
  assign off = {2'b00, pos_r} - {2'b00, crc16fp_pkg::HDR_BYTES} - {2'b00, len_r};

  // per-byte field capture
  always_comb begin
    pos_upd     = pos_r;
    crc_upd     = crc_r;
    seq_upd     = seq_r;
    type_upd    = type_r;
    len_upd     = len_r;
    rcrc_upd    = rcrc_r;
    sync_ok_upd = sync_ok_r;
    tail_ok_upd = tail_ok_r;
    is_pay      = 1'b0;
    if (pos_r != crc16fp_pkg::POS_SAT) begin
      pos_upd = pos_r + 16'd1;
      if (pos_r == 16'd0) begin
        if (s1_byte_r != sync1_r) sync_ok_upd = 1'b0;
      end else if (pos_r == 16'd1) begin
        if (s1_byte_r != sync2_r) sync_ok_upd = 1'b0;
      end else if (pos_r < crc16fp_pkg::HDR_BYTES) begin
        crc_upd = crc_step;
        if (pos_r == 16'd2) begin
          seq_upd[15:8] = s1_byte_r;
        end else if (pos_r == 16'd3) begin
          seq_upd[7:0] = s1_byte_r;
        end else if (pos_r == 16'd4) begin
          type_upd = s1_byte_r;
        end else if (pos_r == 16'd5) begin
          len_upd[15:8] = s1_byte_r;
        end else begin
          len_upd[7:0] = s1_byte_r;
        end
      end else if (off[17]) begin
        crc_upd = crc_step;
        is_pay  = 1'b1;
      end else if (off == 18'd0) begin
        rcrc_upd[7:0] = s1_byte_r;
      end else if (off == 18'd1) begin
        rcrc_upd[15:8] = s1_byte_r;
      end else if (off == 18'd2) begin
        if (s1_byte_r != tail1_r) tail_ok_upd = 1'b0;
      end else if (off == 18'd3) begin
        if (s1_byte_r != tail2_r) tail_ok_upd = 1'b0;
      end
    end
  end

  // summary status, first failing check wins
  always_comb begin
    if (pos_upd < crc16fp_pkg::MIN_BYTES) begin
      st = crc16fp_pkg::ST_SHORT;
    end else if (!sync_ok_upd) begin
      st = crc16fp_pkg::ST_SYNC;
    end else if (type_upd < type_lo_r || type_upd > type_hi_r) begin
      st = crc16fp_pkg::ST_TYPE;
    end else if (len_upd > MaxLen) begin
      st = crc16fp_pkg::ST_LONG;
    end else if ({1'b0, pos_upd} < ({1'b0, len_upd} + crc16fp_pkg::OVERHEAD)) begin
      st = crc16fp_pkg::ST_TRUNCATED;
    end else if (!tail_ok_upd) begin
      st = crc16fp_pkg::ST_TAIL;
    end else if (rcrc_upd != crc_upd) begin
      st = crc16fp_pkg::ST_CRC;
    end else begin
      st = crc16fp_pkg::ST_OK;
    end
  end

  // result word and next frame state
  always_comb begin
    q_data       = '0;
    q_push       = 1'b0;
    pos_nxt      = pos_r;
    crc_nxt      = crc_r;
    seq_nxt      = seq_r;
    type_nxt     = type_r;
    len_nxt      = len_r;
    rcrc_nxt     = rcrc_r;
    sync_ok_nxt  = sync_ok_r;
    tail_ok_nxt  = tail_ok_r;
    if (s1_go) begin
      if (s1_last_r) begin
        q_push              = 1'b1;
        q_data.kind         = 1'b1;
        q_data.status       = st;
        q_data.sequence_res = seq_upd;
        q_data.packet_type  = type_upd;
        q_data.length       = len_upd;
        q_data.rx_crc       = rcrc_upd;
        pos_nxt     = 16'd0;
        crc_nxt     = crc16fp_pkg::CRC_SEED;
        seq_nxt     = 16'd0;
        type_nxt    = 8'd0;
        len_nxt     = 16'd0;
        rcrc_nxt    = 16'd0;
        sync_ok_nxt = 1'b1;
        tail_ok_nxt = 1'b1;
      end else begin
        q_push         = is_pay;
        q_data.payload = s1_byte_r;
        pos_nxt     = pos_upd;
        crc_nxt     = crc_upd;
        seq_nxt     = seq_upd;
        type_nxt    = type_upd;
        len_nxt     = len_upd;
        rcrc_nxt    = rcrc_upd;
        sync_ok_nxt = sync_ok_upd;
        tail_ok_nxt = tail_ok_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 16'd0;
      crc_r     <= crc16fp_pkg::CRC_SEED;
      seq_r     <= 16'd0;
      type_r    <= 8'd0;
      len_r     <= 16'd0;
      rcrc_r    <= 16'd0;
      sync_ok_r <= 1'b1;
      tail_ok_r <= 1'b1;
    end else begin
      pos_r     <= pos_nxt;
      crc_r     <= crc_nxt;
      seq_r     <= seq_nxt;
      type_r    <= type_nxt;
      len_r     <= len_nxt;
      rcrc_r    <= rcrc_nxt;
      sync_ok_r <= sync_ok_nxt;
      tail_ok_r <= tail_ok_nxt;
    end
  end

  crc16fp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q_out)
  );

  assign out_tuser = q_out.kind;
  assign out_tdata = {5'b00000, q_out.rx_crc, q_out.length, q_out.packet_type,
                      q_out.sequence_res, q_out.status, q_out.payload};

  // a result is only ever written into a free queue slot
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("result pushed into full queue");

  // a summary returns the frame state to its start values
  a_clear_after_summary: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_last_r) |=> (pos_r == 16'd0 && crc_r == crc16fp_pkg::CRC_SEED))
    else $error("frame state not cleared after summary");

  // the byte count steps by one per consumed byte until it saturates
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && !s1_last_r && pos_r != crc16fp_pkg::POS_SAT)
      |=> pos_r == $past(pos_r) + 16'd1)
    else $error("byte position did not advance");

  // payload words never come out of the header bytes
  a_pay_after_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !s1_last_r) |-> pos_r >= crc16fp_pkg::HDR_BYTES)
    else $error("payload word from header position");

  // input back-pressure only when the byte register is held by a full queue
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && q_full))
    else $error("input stalled without cause");

endmodule
